/* design/fisr_pkg.sv */
// Package for the reciprocal square root pipeline: constants, stage types and
// the per-stage binary32 multiply and add functions. No dependencies.
`timescale 1ns / 1ps

package fisr_pkg;

  localparam int NEWTON_STEPS = 5;
  localparam int OP_LAT       = 3;
  localparam int STEP_LAT     = 4 * OP_LAT;

  localparam logic [31:0] GUESS_MAGIC  = 32'h5f3759df;
  localparam logic [31:0] HALF_BITS    = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] DEFAULT_NAN  = 32'hffc00000;
  localparam logic [31:0] QUIET_BIT    = 32'h00400000;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic [47:0]        prod;
    logic signed [10:0] exp_sum;
  } fmul_s1_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        ovf;
    logic [7:0]  exp;
    logic [47:0] norm;
    logic        sticky;
  } fmul_s2_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic [7:0]  exp_big;
    logic [26:0] big;
    logic [26:0] lesser;
  } fadd_s1_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic [7:0]  exp_big;
    logic [27:0] sum;
    logic [4:0]  lz;
  } fadd_s2_t;

  // Unpack, handle special operands, form the raw product.
  function automatic fmul_s1_t fmul_st1(input logic [31:0] a, input logic [31:0] b);
    fmul_s1_t   s;
    logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    nan_a  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    s.sign    = a[31] ^ b[31];
    s.prod    = 48'(ma) * 48'(mb);
    s.exp_sum = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
    s.spec    = 1'b1;
    if (nan_a) begin
      s.spec_val = a | QUIET_BIT;
    end else if (nan_b) begin
      s.spec_val = b | QUIET_BIT;
    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
      s.spec_val = DEFAULT_NAN;
    end else if (inf_a || inf_b) begin
      s.spec_val = {s.sign, 8'hff, 23'd0};
    end else if (zero_a || zero_b) begin
      s.spec_val = {s.sign, 31'd0};
    end else begin
      s.spec     = 1'b0;
      s.spec_val = 32'd0;
    end
    return s;
  endfunction

  // Count leading zeros of the product and normalize, or denormalize with sticky.
  function automatic fmul_s2_t fmul_st2(input fmul_s1_t s);
    fmul_s2_t           r;
    logic [5:0]         lz;
    logic signed [10:0] e;
    logic signed [10:0] rs;
    logic [5:0]         rr;
    logic [97:0]        wide;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s.prod[i]) lz = 6'(47 - i);
    end
    e  = s.exp_sum - $signed({5'd0, lz});
    rs = 11'sd1 - s.exp_sum;
    rr = (rs > 11'sd50) ? 6'd50 : rs[5:0];
    r.spec     = s.spec;
    r.spec_val = s.spec_val;
    r.sign     = s.sign;
    r.ovf      = (e >= 11'sd255);
    r.sticky   = 1'b0;
    if (e >= 11'sd1) begin
      r.exp  = e[7:0];
      r.norm = s.prod << lz;
    end else if (s.exp_sum >= 11'sd1) begin
      r.exp  = 8'd0;
      r.norm = s.prod << 6'(s.exp_sum - 11'sd1);
    end else begin
      r.exp    = 8'd0;
      wide     = {s.prod, 50'd0} >> rr;
      r.norm   = wide[97:50];
      r.sticky = |wide[49:0];
    end
    return r;
  endfunction

  // Round to nearest even and pack; mantissa carry rolls into the exponent.
  function automatic logic [31:0] fmul_st3(input fmul_s2_t s);
    logic        inc;
    logic [30:0] mag;
    inc = s.norm[23] && ((|s.norm[22:0]) || s.sticky || s.norm[24]);
    mag = {s.exp, s.norm[46:24]} + 31'(inc);
    if (s.spec) return s.spec_val;
    if (s.ovf) return {s.sign, 8'hff, 23'd0};
    return {s.sign, mag};
  endfunction

  // a - b: unpack, order by magnitude, align the smaller operand with sticky.
  function automatic fadd_s1_t fadd_st1(input logic [31:0] a, input logic [31:0] b);
    fadd_s1_t    s;
    logic [31:0] nb, big_v, sml_v;
    logic        nan_a, nan_b, inf_a, inf_b;
    logic [7:0]  eb_e, es_e, d;
    logic [23:0] mb, ms;
    logic [52:0] tmp;
    nb    = {~b[31], b[30:0]};
    nan_a = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    if (a[30:0] >= nb[30:0]) begin
      big_v = a;
      sml_v = nb;
    end else begin
      big_v = nb;
      sml_v = a;
    end
    eb_e = (big_v[30:23] == 8'd0) ? 8'd1 : big_v[30:23];
    es_e = (sml_v[30:23] == 8'd0) ? 8'd1 : sml_v[30:23];
    mb   = {(big_v[30:23] != 8'd0), big_v[22:0]};
    ms   = {(sml_v[30:23] != 8'd0), sml_v[22:0]};
    d    = eb_e - es_e;
    tmp  = {ms, 29'd0} >> d[4:0];
    s.sign    = big_v[31];
    s.sub     = a[31] ^ nb[31];
    s.exp_big = eb_e;
    s.big     = {mb, 3'b000};
    if (d >= 8'd27) begin
      s.lesser = {26'd0, |ms};
    end else begin
      s.lesser = {tmp[52:27], tmp[26] | (|tmp[25:0])};
    end
    s.spec = 1'b1;
    if (nan_a) begin
      s.spec_val = a | QUIET_BIT;
    end else if (nan_b) begin
      s.spec_val = b | QUIET_BIT;
    end else if (inf_a && inf_b && (a[31] != nb[31])) begin
      s.spec_val = DEFAULT_NAN;
    end else if (inf_a) begin
      s.spec_val = a;
    end else if (inf_b) begin
      s.spec_val = nb;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      s.spec_val = {a[31] & nb[31], 31'd0};
    end else begin
      s.spec     = 1'b0;
      s.spec_val = 32'd0;
    end
    return s;
  endfunction

  // Add or subtract the aligned mantissas and count leading zeros.
  function automatic fadd_s2_t fadd_st2(input fadd_s1_t s);
    fadd_s2_t r;
    r.spec     = s.spec;
    r.spec_val = s.spec_val;
    r.sign     = s.sign;
    r.exp_big  = s.exp_big;
    r.sum      = s.sub ? ({1'b0, s.big} - {1'b0, s.lesser}) : ({1'b0, s.big} + {1'b0, s.lesser});
    r.lz       = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (r.sum[i]) r.lz = 5'(27 - i);
    end
    return r;
  endfunction

  // Normalize, round to nearest even and pack.
  function automatic logic [31:0] fadd_st3(input fadd_s2_t s);
    logic signed [9:0] e;
    logic [27:0]       n;
    logic [7:0]        ex;
    logic              inc;
    logic [30:0]       mag;
    e = $signed({2'b00, s.exp_big}) + 10'sd1 - $signed({5'd0, s.lz});
    if (e >= 10'sd1) begin
      n  = s.sum << s.lz;
      ex = e[7:0];
    end else begin
      n  = s.sum << s.exp_big[4:0];
      ex = 8'd0;
    end
    inc = n[3] && ((|n[2:0]) || n[4]);
    mag = {ex, n[26:4]} + 31'(inc);
    if (s.spec) return s.spec_val;
    if (s.sum == 28'd0) return 32'd0;
    if (e >= 10'sd255) return {s.sign, 8'hff, 23'd0};
    return {s.sign, mag};
  endfunction

endpackage

/* design/fisr_step.sv */
// One Newton refinement step y*(1.5 - xhalf*y*y) as a twelve-stage pipeline.
// Depends on fisr_pkg for the stage types and float stage functions.
`timescale 1ns / 1ps

module fisr_step
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_xhalf,
  input  logic [31:0] in_y,
  output logic        out_valid,
  output logic [31:0] out_xhalf,
  output logic [31:0] out_y
);

  logic        v_r     [STEP_LAT];
  logic [31:0] y_dly_r [STEP_LAT];
  logic [31:0] xh_dly_r[STEP_LAT];

  fmul_s1_t    m1a_r, m2a_r, m3a_r;
  fmul_s2_t    m1b_r, m2b_r, m3b_r;
  fadd_s1_t    s1_r;
  fadd_s2_t    s2_r;
  logic [31:0] t1_r, t2_r, t3_r, y_r;

  // Valid bits travel with the data; advance only when the pipe is enabled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STEP_LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < STEP_LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_dly_r[0]  <= in_y;
      xh_dly_r[0] <= in_xhalf;
      for (int i = 1; i < STEP_LAT; i++) begin
        y_dly_r[i]  <= y_dly_r[i-1];
        xh_dly_r[i] <= xh_dly_r[i-1];
      end
      m1a_r <= fmul_st1(in_xhalf, in_y);
      m1b_r <= fmul_st2(m1a_r);
      t1_r  <= fmul_st3(m1b_r);
      m2a_r <= fmul_st1(t1_r, y_dly_r[OP_LAT-1]);
      m2b_r <= fmul_st2(m2a_r);
      t2_r  <= fmul_st3(m2b_r);
      s1_r  <= fadd_st1(THREE_HALVES, t2_r);
      s2_r  <= fadd_st2(s1_r);
      t3_r  <= fadd_st3(s2_r);
      m3a_r <= fmul_st1(y_dly_r[3*OP_LAT-1], t3_r);
      m3b_r <= fmul_st2(m3a_r);
      y_r   <= fmul_st3(m3b_r);
    end
  end

  assign out_valid = v_r[STEP_LAT-1];
  assign out_xhalf = xh_dly_r[STEP_LAT-1];
  assign out_y     = y_r;

endmodule

/* design/fast_inverse_square_root.sv */
// Reciprocal square root: magic-constant guess refined by Newton steps, binary32.
// Accepts one transaction per cycle while no result is held by a stalled output.
// Every float op is a three-stage multiply or add; a stall at the output freezes
// the whole pipe, so a transaction is never lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Depends on fisr_pkg and fisr_step.
`timescale 1ns / 1ps

module fast_inverse_square_root
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);

  logic        en;
  logic        v_r [OP_LAT];
  logic [31:0] g_r [OP_LAT];
  fmul_s1_t    h1_r;
  fmul_s2_t    h2_r;
  logic [31:0] h3_r;

  logic        st_v [NEWTON_STEPS+1];
  logic [31:0] st_xh[NEWTON_STEPS+1];
  logic [31:0] st_y [NEWTON_STEPS+1];

  // Hold every stage while a finished result waits on a stalled consumer.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OP_LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < OP_LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Compute xhalf = 0.5*x while the integer guess travels alongside.
  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0] <= GUESS_MAGIC - {in_operand_bits[31], in_operand_bits[31:1]};
      for (int i = 1; i < OP_LAT; i++) g_r[i] <= g_r[i-1];
      h1_r <= fmul_st1(HALF_BITS, in_operand_bits);
      h2_r <= fmul_st2(h1_r);
      h3_r <= fmul_st3(h2_r);
    end
  end

  assign st_v[0]  = v_r[OP_LAT-1];
  assign st_xh[0] = h3_r;
  assign st_y[0]  = g_r[OP_LAT-1];

  // Chain the Newton steps; each passes xhalf on to the next.
  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
    fisr_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (st_v[k]),
      .in_xhalf (st_xh[k]),
      .in_y     (st_y[k]),
      .out_valid(st_v[k+1]),
      .out_xhalf(st_xh[k+1]),
      .out_y    (st_y[k+1])
    );
  end

  assign out_valid       = st_v[NEWTON_STEPS];
  assign out_result_bits = st_y[NEWTON_STEPS];

`ifndef SYNTHESIS
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_result_bits))
    else $error("result data changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");
`endif

endmodule
